### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SIM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/sim_pkg.sv
// Types, constants and helpers of the small integer matrix unit.
package sim_pkg;

	localparam int MAX_SIDE = 8;
	localparam int CELLS    = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int POS_W    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
	localparam int CFG_W    = 4;
	localparam int REG_W    = 2;
	localparam int IDX_W    = 3;
	localparam int DATA_W   = 32;
	localparam int STAT_W   = 2;
	localparam int CMD_W    = 3;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE = 3'd0,
		CMD_READ  = 3'd1,
		CMD_ROW   = 3'd2,
		CMD_COL   = 3'd3,
		CMD_MAIN  = 3'd4,
		CMD_SEC   = 3'd5,
		CMD_MUL   = 3'd6
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [REG_W-1:0] {
		REG_ROWS_A = 2'd0,
		REG_COLS_A = 2'd1,
		REG_ROWS_B = 2'd2,
		REG_COLS_B = 2'd3
	} reg_t;

	typedef enum logic [1:0] {
		OP_RESULT = 2'd0,
		OP_WRITE  = 2'd1,
		OP_WALK   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		AM_FIXED = 3'd0,
		AM_ROW   = 3'd1,
		AM_COL   = 3'd2,
		AM_MAIN  = 3'd3,
		AM_SEC   = 3'd4,
		AM_MUL   = 3'd5
	} amode_t;

	typedef struct packed {
		logic [SIDE_W-1:0] rows_a;
		logic [SIDE_W-1:0] cols_a;
		logic [SIDE_W-1:0] rows_b;
		logic [SIDE_W-1:0] cols_b;
	} dims_t;

	typedef struct packed {
		op_t               op;
		amode_t            amode;
		logic              sel_b;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [SIDE_W-1:0] cnt;
		logic [SIDE_W-1:0] nrow;
		logic [SIDE_W-1:0] ncol;
		status_t           status;
		logic [DATA_W-1:0] wdata;
	} job_t;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		if (int'(v) > MAX_SIDE) begin
			return SIDE_W'(MAX_SIDE);
		end
		return SIDE_W'(v);
	endfunction

	function automatic logic [ADDR_W-1:0] addr_of(input logic [POS_W-1:0] r,
		input logic [POS_W-1:0] c);
		return ADDR_W'(int'(r) * MAX_SIDE + int'(c));
	endfunction

endpackage

### src/sim_queue.sv
// Command queue between the front and the back of the matrix unit.
module sim_queue import sim_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output job_t pop_job
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (int'(cnt_q) == QDEPTH);
	assign q_valid = (cnt_q != '0);
	assign pop_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (int'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (int'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### src/sim_front.sv
// Input handshake and command classification of the matrix unit.
module sim_front import sim_pkg::*; (
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic                     matrix_select,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [DATA_W-1:0] write_value,
	input  dims_t                    dims,
	input  logic                     q_full,
	output logic                     push,
	output job_t                     job
);

	logic [SIDE_W-1:0] nr;
	logic [SIDE_W-1:0] nc;
	logic [SIDE_W-1:0] nd;
	logic              r_ok;
	logic              c_ok;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		nr   = matrix_select ? dims.rows_b : dims.rows_a;
		nc   = matrix_select ? dims.cols_b : dims.cols_a;
		nd   = (nr < nc) ? nr : nc;
		r_ok = int'(row_index) < int'(nr);
		c_ok = int'(col_index) < int'(nc);

		job        = '0;
		job.op     = OP_RESULT;
		job.amode  = AM_FIXED;
		job.status = ST_RANGE;
		job.sel_b  = matrix_select;
		job.row    = POS_W'(row_index);
		job.col    = POS_W'(col_index);
		job.wdata  = write_value;

		unique case (cmd_t'(command))
			CMD_WRITE: begin
				if (r_ok && c_ok) begin
					job.op     = OP_WRITE;
					job.status = ST_OK;
				end
			end
			CMD_READ: begin
				if (r_ok && c_ok) begin
					job.op     = OP_WALK;
					job.status = ST_OK;
					job.cnt    = SIDE_W'(1);
				end
			end
			CMD_ROW: begin
				if (r_ok) begin
					job.op     = OP_WALK;
					job.amode  = AM_ROW;
					job.status = ST_OK;
					job.cnt    = nc;
				end
			end
			CMD_COL: begin
				if (c_ok) begin
					job.op     = OP_WALK;
					job.amode  = AM_COL;
					job.status = ST_OK;
					job.cnt    = nr;
				end
			end
			CMD_MAIN: begin
				job.op     = OP_WALK;
				job.amode  = AM_MAIN;
				job.status = ST_OK;
				job.cnt    = nd;
			end
			CMD_SEC: begin
				job.op     = OP_WALK;
				job.amode  = AM_SEC;
				job.status = ST_OK;
				job.cnt    = nd;
				job.ncol   = nc;
			end
			CMD_MUL: begin
				if (dims.cols_a != dims.rows_b) begin
					job.status = ST_MISMATCH;
				end else if (dims.rows_a == '0 || dims.cols_b == '0) begin
					job.status = ST_EMPTY;
				end else begin
					job.op     = OP_WALK;
					job.amode  = AM_MUL;
					job.status = ST_OK;
					job.cnt    = dims.cols_a;
					job.nrow   = dims.rows_a;
					job.ncol   = dims.cols_b;
				end
			end
			default: begin
				job.status = ST_RANGE;
			end
		endcase
	end

endmodule

### src/sim_back.sv
// Execution sequencer, matrix stores and result register of the matrix unit.
module sim_back import sim_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  job_t                     q_job,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] result_value,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic [STAT_W-1:0]        status,
	output logic                     last
);

	typedef enum logic [4:0] {
		S_IDLE     = 5'b00001,
		S_DISPATCH = 5'b00010,
		S_ISSUE    = 5'b00100,
		S_DRAIN    = 5'b01000,
		S_EMIT     = 5'b10000
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic [POS_W-1:0]  pi_q;
	logic [POS_W-1:0]  pj_q;
	logic [POS_W-1:0]  k_q;
	logic [DATA_W-1:0] acc_q;

	logic [DATA_W-1:0] mem_a [CELLS];
	logic [DATA_W-1:0] mem_b [CELLS];
	logic [CELLS-1:0]  vld_a_q;
	logic [CELLS-1:0]  vld_b_q;

	logic              v_s1;
	logic              v_s2;
	logic [DATA_W-1:0] rd_a_s1;
	logic [DATA_W-1:0] rd_b_s1;
	logic              va_s1;
	logic              vb_s1;
	logic [DATA_W-1:0] prod_s2;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	logic [IDX_W-1:0]  out_row_q;
	logic [IDX_W-1:0]  out_col_q;
	logic [STAT_W-1:0] out_status_q;
	logic              out_last_q;

	logic              is_mul;
	logic              last_k;
	logic              last_elem;
	logic              out_free;
	logic              wr_a;
	logic              wr_b;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] addr_a;
	logic [ADDR_W-1:0] addr_b;
	logic [POS_W-1:0]  sec_col;
	logic [DATA_W-1:0] opa;
	logic [DATA_W-1:0] opb;
	logic [DATA_W-1:0] term;

	assign is_mul    = (job_q.amode == AM_MUL);
	assign last_k    = (int'(k_q) + 1 == int'(job_q.cnt));
	assign last_elem = (int'(pi_q) + 1 == int'(job_q.nrow))
		&& (int'(pj_q) + 1 == int'(job_q.ncol));
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign waddr     = addr_of(job_q.row, job_q.col);
	assign wr_a      = (state_q == S_DISPATCH) && (job_q.op == OP_WRITE) && !job_q.sel_b;
	assign wr_b      = (state_q == S_DISPATCH) && (job_q.op == OP_WRITE) && job_q.sel_b;
	assign sec_col   = POS_W'(int'(job_q.ncol) - 1 - int'(k_q));

	always_comb begin
		unique case (job_q.amode)
			AM_FIXED: addr_a = addr_of(job_q.row, job_q.col);
			AM_ROW:   addr_a = addr_of(job_q.row, k_q);
			AM_COL:   addr_a = addr_of(k_q, job_q.col);
			AM_MAIN:  addr_a = addr_of(k_q, k_q);
			AM_SEC:   addr_a = addr_of(k_q, sec_col);
			AM_MUL:   addr_a = addr_of(pi_q, k_q);
			default:  addr_a = '0;
		endcase
		addr_b = is_mul ? addr_of(k_q, pj_q) : addr_a;
	end

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[waddr] <= job_q.wdata;
		end
		if (wr_b) begin
			mem_b[waddr] <= job_q.wdata;
		end
		rd_a_s1 <= mem_a[addr_a];
		rd_b_s1 <= mem_b[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q <= '0;
			vld_b_q <= '0;
		end else begin
			if (wr_a) begin
				vld_a_q[waddr] <= 1'b1;
			end
			if (wr_b) begin
				vld_b_q[waddr] <= 1'b1;
			end
		end
	end

	assign opa  = va_s1 ? rd_a_s1 : '0;
	assign opb  = vb_s1 ? rd_b_s1 : '0;
	assign term = is_mul ? DATA_W'(opa * opb) : (job_q.sel_b ? opb : opa);

	always_ff @(posedge clk) begin
		va_s1   <= vld_a_q[addr_a];
		vb_s1   <= vld_b_q[addr_b];
		prod_s2 <= term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_ISSUE);
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= q_job;
		end
		if (state_q == S_DISPATCH) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + prod_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pi_q    <= '0;
			pj_q    <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						pi_q    <= '0;
						pj_q    <= '0;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					k_q <= '0;
					if (job_q.op == OP_WALK && job_q.cnt != '0) begin
						state_q <= S_ISSUE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_ISSUE: begin
					k_q <= k_q + 1'b1;
					if (last_k) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (is_mul && job_q.op == OP_WALK && !last_elem) begin
							if (int'(pj_q) + 1 == int'(job_q.ncol)) begin
								pj_q <= '0;
								pi_q <= pi_q + 1'b1;
							end else begin
								pj_q <= pj_q + 1'b1;
							end
							state_q <= S_DISPATCH;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_value_q  <= (job_q.op == OP_WALK) ? acc_q : '0;
			out_status_q <= job_q.status;
			if (is_mul && job_q.op == OP_WALK) begin
				out_row_q  <= IDX_W'(pi_q);
				out_col_q  <= IDX_W'(pj_q);
				out_last_q <= last_elem;
			end else begin
				out_row_q  <= '0;
				out_col_q  <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = out_value_q;
	assign out_row      = out_row_q;
	assign out_col      = out_col_q;
	assign status       = out_status_q;
	assign last         = out_last_q;

endmodule

### src/small_integer_matrix_unit_core.sv
// Top level of the small integer matrix unit: size registers, front, queue and back.
// Holds matrices A and B (signed 32-bit, up to 8 by 8, zero after reset) and runs one
// command at a time from a four-entry queue, so new commands are taken while earlier ones
// still execute. Each matrix has one memory read port, and the back end reads one element
// of each matrix per cycle through a two-stage read and multiply pipeline. A write, a
// rejected command or a size error goes from dispatch straight to emit; a read or a row,
// column or diagonal sum issues its elements, drains the pipeline and then emits; a
// multiply runs one such inner loop per product element. Sizes may be changed only
// while no command is in flight; values above 8 act as 8. No clearing pass after reset.
module small_integer_matrix_unit_core import sim_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_write_en,
	input  logic [REG_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic                     matrix_select,
	input  logic [IDX_W-1:0]         row_index,
	input  logic [IDX_W-1:0]         col_index,
	input  logic signed [DATA_W-1:0] write_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] result_value,
	output logic [IDX_W-1:0]         out_row,
	output logic [IDX_W-1:0]         out_col,
	output logic [STAT_W-1:0]        status,
	output logic                     last
);

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] cols_a_q;
	logic [CFG_W-1:0] rows_b_q;
	logic [CFG_W-1:0] cols_b_q;
	dims_t            dims;
	job_t             push_job;
	job_t             pop_job;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= '0;
			cols_a_q <= '0;
			rows_b_q <= '0;
			cols_b_q <= '0;
		end else if (cfg_write_en) begin
			unique case (reg_t'(cfg_index))
				REG_ROWS_A: rows_a_q <= cfg_data;
				REG_COLS_A: cols_a_q <= cfg_data;
				REG_ROWS_B: rows_b_q <= cfg_data;
				REG_COLS_B: cols_b_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		dims.rows_a = clamp_side(rows_a_q);
		dims.cols_a = clamp_side(cols_a_q);
		dims.rows_b = clamp_side(rows_b_q);
		dims.cols_b = clamp_side(cols_b_q);
	end

	sim_front u_front (
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.matrix_select (matrix_select),
		.row_index     (row_index),
		.col_index     (col_index),
		.write_value   (write_value),
		.dims          (dims),
		.q_full        (q_full),
		.push          (push),
		.job           (push_job)
	);

	sim_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.q_valid  (q_valid),
		.pop_job  (pop_job)
	);

	sim_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (pop_job),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.status       (status),
		.last         (last)
	);

endmodule

### src/sim_checker.sv
// Port-level checks of the matrix unit result channel, bound to the top level.
`include "assert_macros.svh"

module sim_checker import sim_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] result_value,
	input logic [IDX_W-1:0]         out_row,
	input logic [IDX_W-1:0]         out_col,
	input logic [STAT_W-1:0]        status,
	input logic                     last
);

	`SIM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(status) && $stable(last) && $stable(out_row) && $stable(out_col), "result item changed while stalled")

	`SIM_ASSERT_NOW(a_err_single, out_valid && status != ST_OK, last && result_value == 0 && out_row == 0 && out_col == 0, "error item is not a single zero result")

	`SIM_ASSERT_NOW(a_nonlast_ok, out_valid && !last, status == ST_OK, "non-final item carries an error status")

endmodule

bind small_integer_matrix_unit_core sim_checker u_sim_checker (.*);

### dv/tb_top.sv
// Self-checking bench for the matrix unit: size settings, element access, sums and products.
`timescale 1ns / 1ps

module tb_top;
	import sim_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNDEF = 3'd7;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_COMMANDS = 500;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic              sel;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DATA_W-1:0] wval;
	} cmd_item_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		status_t           stat;
		logic              last;
	} result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write_en = 1'b0;
	logic [REG_W-1:0]         cfg_index = '0;
	logic [CFG_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [CMD_W-1:0]         command = '0;
	logic                     matrix_select = 1'b0;
	logic [IDX_W-1:0]         row_index = '0;
	logic [IDX_W-1:0]         col_index = '0;
	logic [DATA_W-1:0]        write_value = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] result_value;
	logic [IDX_W-1:0]         out_row;
	logic [IDX_W-1:0]         out_col;
	logic [STAT_W-1:0]        status;
	logic                     last;

	logic [DATA_W-1:0] mat_a [CELLS];
	logic [DATA_W-1:0] mat_b [CELLS];
	logic [CFG_W-1:0]  size_reg [4] = '{default: '0};

	cmd_item_t pending_commands [$];
	result_t   expected_results [$];
	cmd_item_t held_item;
	logic      held = 1'b0;
	logic      steady = 1'b0;

	int burst_left = 0;
	int gap_left = 0;
	int errors = 0;
	int commands_done = 0;
	int multiplies_done = 0;
	int results_checked = 0;
	int flagged_results = 0;
	int size_settings = 0;
	int cycles = 0;
	logic [15:0] stall_pat = 16'hffff;
	int stall_age = 0;

	small_integer_matrix_unit_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.matrix_select(matrix_select),
		.row_index    (row_index),
		.col_index    (col_index),
		.write_value  (write_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.out_row      (out_row),
		.out_col      (out_col),
		.status       (status),
		.last         (last)
	);

	always #5 clk = ~clk;

	function automatic int side_limit(logic [CFG_W-1:0] v);
		return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
	endfunction

	function automatic logic [DATA_W-1:0] element_of(logic sel, int r, int c);
		return sel ? mat_b[r * MAX_SIDE + c] : mat_a[r * MAX_SIDE + c];
	endfunction

	function automatic void expect_single(logic [DATA_W-1:0] value, status_t stat);
		expected_results.push_back('{value, '0, '0, stat, 1'b1});
	endfunction

	function automatic void predict_results(cmd_item_t it);
		int nr, nc, nd, ra, ca, rb, cb;
		logic [DATA_W-1:0] acc;
		nr = side_limit(it.sel ? size_reg[REG_ROWS_B] : size_reg[REG_ROWS_A]);
		nc = side_limit(it.sel ? size_reg[REG_COLS_B] : size_reg[REG_COLS_A]);
		nd = (nr < nc) ? nr : nc;
		ra = side_limit(size_reg[REG_ROWS_A]);
		ca = side_limit(size_reg[REG_COLS_A]);
		rb = side_limit(size_reg[REG_ROWS_B]);
		cb = side_limit(size_reg[REG_COLS_B]);
		acc = '0;
		case (it.cmd)
			CMD_WRITE: begin
				if (it.row < nr && it.col < nc) begin
					if (it.sel)
						mat_b[it.row * MAX_SIDE + it.col] = it.wval;
					else
						mat_a[it.row * MAX_SIDE + it.col] = it.wval;
					expect_single('0, ST_OK);
				end else begin
					expect_single('0, ST_RANGE);
				end
			end
			CMD_READ: begin
				if (it.row < nr && it.col < nc)
					expect_single(element_of(it.sel, it.row, it.col), ST_OK);
				else
					expect_single('0, ST_RANGE);
			end
			CMD_ROW: begin
				if (it.row >= nr) begin
					expect_single('0, ST_RANGE);
				end else begin
					for (int i = 0; i < nc; i++)
						acc = acc + element_of(it.sel, it.row, i);
					expect_single(acc, ST_OK);
				end
			end
			CMD_COL: begin
				if (it.col >= nc) begin
					expect_single('0, ST_RANGE);
				end else begin
					for (int i = 0; i < nr; i++)
						acc = acc + element_of(it.sel, i, it.col);
					expect_single(acc, ST_OK);
				end
			end
			CMD_MAIN: begin
				for (int i = 0; i < nd; i++)
					acc = acc + element_of(it.sel, i, i);
				expect_single(acc, ST_OK);
			end
			CMD_SEC: begin
				for (int i = 0; i < nd; i++)
					acc = acc + element_of(it.sel, i, nc - 1 - i);
				expect_single(acc, ST_OK);
			end
			CMD_MUL: begin
				multiplies_done++;
				if (ca != rb) begin
					expect_single('0, ST_MISMATCH);
				end else if (ra == 0 || cb == 0) begin
					expect_single('0, ST_EMPTY);
				end else begin
					for (int i = 0; i < ra; i++) begin
						for (int j = 0; j < cb; j++) begin
							acc = '0;
							for (int k = 0; k < ca; k++)
								acc = acc + mat_a[i * MAX_SIDE + k] * mat_b[k * MAX_SIDE + j];
							expected_results.push_back('{acc, IDX_W'(i), IDX_W'(j), ST_OK,
								(i == ra - 1 && j == cb - 1)});
						end
					end
				end
			end
			default: expect_single('0, ST_RANGE);
		endcase
	endfunction

	function automatic int pick_index(int n);
		if (n > 0 && $urandom_range(0, 99) < 85)
			return $urandom_range(0, n - 1);
		return $urandom_range(0, (1 << IDX_W) - 1);
	endfunction

	function automatic cmd_item_t random_command();
		cmd_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)      it.cmd = CMD_WRITE;
		else if (pick < 50) it.cmd = CMD_READ;
		else if (pick < 60) it.cmd = CMD_ROW;
		else if (pick < 70) it.cmd = CMD_COL;
		else if (pick < 78) it.cmd = CMD_MAIN;
		else if (pick < 86) it.cmd = CMD_SEC;
		else if (pick < 97) it.cmd = CMD_MUL;
		else                it.cmd = CMD_UNDEF;
		it.sel = 1'($urandom_range(0, 1));
		it.row = IDX_W'(pick_index(side_limit(it.sel ? size_reg[REG_ROWS_B]
			: size_reg[REG_ROWS_A])));
		it.col = IDX_W'(pick_index(side_limit(it.sel ? size_reg[REG_COLS_B]
			: size_reg[REG_COLS_A])));
		case ($urandom_range(0, 7))
			0:       it.wval = 32'h7fff_ffff;
			1:       it.wval = 32'h8000_0000;
			2:       it.wval = 32'hffff_ffff;
			3, 4:    it.wval = DATA_W'($urandom_range(0, 200) - 100);
			default: it.wval = $urandom;
		endcase
		return it;
	endfunction

	function automatic logic [CFG_W-1:0] random_side();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return CFG_W'(MAX_SIDE);
			2:       return CFG_W'($urandom_range(MAX_SIDE + 1, (1 << CFG_W) - 1));
			default: return CFG_W'($urandom_range(1, MAX_SIDE));
		endcase
	endfunction

	task automatic queue_command(logic [CMD_W-1:0] cmd, logic sel, int r, int c,
		logic [DATA_W-1:0] v);
		pending_commands.push_back('{cmd, sel, IDX_W'(r), IDX_W'(c), v});
	endtask

	task automatic write_size(reg_t idx, logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		size_reg[idx] = v;
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic set_sizes(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] ca,
		logic [CFG_W-1:0] rb, logic [CFG_W-1:0] cb);
		write_size(REG_ROWS_A, ra);
		write_size(REG_COLS_A, ca);
		write_size(REG_ROWS_B, rb);
		write_size(REG_COLS_B, cb);
		size_settings++;
	endtask

	task automatic wait_idle();
		while (pending_commands.size() != 0 || held || expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				predict_results(held_item);
				held = 1'b0;
				commands_done++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_commands.size() > 0) begin
					held_item = pending_commands.pop_front();
					held = 1'b1;
					command <= held_item.cmd;
					matrix_select <= held_item.sel;
					row_index <= held_item.row;
					col_index <= held_item.col;
					write_value <= held_item.wval;
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						if (!steady && $urandom_range(0, 3) != 0)
							gap_left = $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t exp_res;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_checked++;
				if (status != ST_OK)
					flagged_results++;
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, actual value %h status %0d",
						$time, result_value, status);
				end else begin
					exp_res = expected_results.pop_front();
					if (result_value !== exp_res.value || out_row !== exp_res.row ||
						out_col !== exp_res.col || status !== exp_res.stat ||
						last !== exp_res.last) begin
						errors++;
						$display("%0t: mismatch: expected value %h row %0d col %0d status %0d last %0b, actual value %h row %0d col %0d status %0d last %0b",
							$time, exp_res.value, exp_res.row, exp_res.col, exp_res.stat,
							exp_res.last, result_value, out_row, out_col, status, last);
					end
				end
			end
			out_ready <= steady ? 1'b1 : stall_pat[0];
			if (stall_age == 47) begin
				stall_age <= 0;
				stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
			end else begin
				stall_age <= stall_age + 1;
				stall_pat <= {stall_pat[0], stall_pat[15:1]};
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles with %0d results outstanding",
				$time, CYCLE_LIMIT, expected_results.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int random_queued;
		int n;
		logic [CFG_W-1:0] ra, ca, rb, cb;
		random_queued = 0;
		for (int i = 0; i < CELLS; i++) begin
			mat_a[i] = '0;
			mat_b[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		queue_command(CMD_READ, 1'b0, 0, 0, '0);
		queue_command(CMD_SEC, 1'b1, 0, 0, '0);
		queue_command(CMD_MUL, 1'b0, 0, 0, '0);
		queue_command(CMD_UNDEF, 1'b1, 7, 7, 32'hffff_ffff);
		queue_command(CMD_WRITE, 1'b0, 0, 0, 32'h1234_5678);
		wait_idle();

		set_sizes(8, 8, 8, 8);
		queue_command(CMD_WRITE, 1'b0, 0, 0, 32'h7fff_ffff);
		queue_command(CMD_WRITE, 1'b0, 0, 7, 32'h7fff_ffff);
		queue_command(CMD_WRITE, 1'b0, 7, 7, 32'h8000_0000);
		queue_command(CMD_WRITE, 1'b1, 7, 0, 32'hffff_ffff);
		queue_command(CMD_WRITE, 1'b1, 0, 7, 32'h0000_0002);
		queue_command(CMD_READ, 1'b0, 7, 7, '0);
		queue_command(CMD_READ, 1'b1, 7, 0, '0);
		queue_command(CMD_ROW, 1'b0, 0, 3, '0);
		queue_command(CMD_COL, 1'b1, 5, 7, '0);
		queue_command(CMD_MAIN, 1'b0, 0, 0, '0);
		queue_command(CMD_SEC, 1'b1, 0, 0, '0);
		queue_command(CMD_MUL, 1'b1, 0, 0, '0);
		wait_idle();

		set_sizes(15, 3, 2, 5);
		queue_command(CMD_MUL, 1'b0, 0, 0, '0);
		queue_command(CMD_WRITE, 1'b0, 1, 5, 32'h5555_aaaa);
		queue_command(CMD_READ, 1'b1, 2, 0, '0);
		queue_command(CMD_ROW, 1'b1, 2, 0, '0);
		queue_command(CMD_COL, 1'b0, 0, 3, '0);
		queue_command(CMD_SEC, 1'b0, 0, 0, '0);
		wait_idle();

		set_sizes(3, 0, 0, 4);
		queue_command(CMD_MUL, 1'b0, 0, 0, '0);
		wait_idle();

		set_sizes(2, 12, 9, 0);
		queue_command(CMD_MUL, 1'b1, 0, 0, '0);
		wait_idle();

		while (random_queued < RANDOM_COMMANDS) begin
			ra = random_side();
			ca = random_side();
			rb = ($urandom_range(0, 9) < 6) ? ca : random_side();
			cb = random_side();
			set_sizes(ra, ca, rb, cb);
			steady = ($urandom_range(0, 4) == 0);
			n = $urandom_range(20, 45);
			repeat (n) pending_commands.push_back(random_command());
			random_queued += n;
			wait_idle();
		end

		steady = 1'b0;
		wait_idle();
		repeat (16) @(posedge clk);
		$display("Ran %0d commands, %0d of them multiplies, under %0d size settings.",
			commands_done, multiplies_done, size_settings);
		$display("Checked %0d results, %0d of them with a flagged status.",
			results_checked, flagged_results);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
